/* rtl/sfsd_pkg.sv */
// Shared types, constants and helper functions for the SBUS frame stick decoder.
// Used by every module of the block; no dependencies of its own.
package sfsd_pkg;

  // byte stream framing
  localparam int unsigned ByteW        = 8;
  localparam int unsigned PayloadBytes = 22;
  localparam int unsigned PayloadBits  = PayloadBytes * ByteW;
  localparam int unsigned IdxW         = 5;
  localparam logic [IdxW-1:0] IdxFirst = IdxW'(1);
  localparam logic [IdxW-1:0] IdxLast  = IdxW'(PayloadBytes);
  localparam logic [IdxW-1:0] IdxFlag  = IdxW'(PayloadBytes + 1);

  // flag byte bits
  localparam int unsigned FrameLostBit = 2;
  localparam int unsigned FailsafeBit  = 3;

  // channel packing, only channels 0 to 9 are used
  localparam int unsigned ChanW     = 11;
  localparam int unsigned NumChans  = 10;
  localparam int unsigned ChanBits  = NumChans * ChanW;
  localparam int unsigned NumSticks = 6;
  localparam int unsigned NumSw     = 4;
  localparam int unsigned SwBase    = 6;
  localparam int unsigned StickW    = 11;
  localparam int unsigned SwW       = 2;
  localparam int unsigned MagW      = 10;
  localparam logic [ChanW-1:0] ChanCenter = ChanW'(1024);

  // reciprocal scaling, q = (mag * coef + bias) >> ScaleShift
  // positive side: floor((1320*v + 783) / 1566)
  // negative side: floor((330*u + 195) / 392), pre-scaled by 4 to share the shift
  localparam int unsigned ScaleShift = 32;
  localparam int unsigned CoefW      = 32;
  localparam int unsigned ProdW      = 43;
  localparam logic [CoefW-1:0] PosCoef = 32'd3620279520;
  localparam logic [CoefW-1:0] PosBias = 32'd2147483988;
  localparam logic [CoefW-1:0] NegCoef = 32'd3615662160;
  localparam logic [CoefW-1:0] NegBias = 32'd2136527640;

  // switch codes
  localparam logic signed [SwW-1:0] SwNeg  = -2'sd1;
  localparam logic signed [SwW-1:0] SwZero = 2'sd0;
  localparam logic signed [SwW-1:0] SwPos  = 2'sd1;

  // decoded frame handed from the byte assembler to the mapping stage
  typedef struct packed {
    logic [ChanBits-1:0] chans;
    logic                link_lost;
    logic                failsafe;
  } frame_t;

  // stick slot to SBUS channel, slots 2 and 3 swapped
  function automatic int unsigned stick_chan(input int unsigned slot);
    int unsigned ch;
    ch = slot;
    if (slot == 2) ch = 3;
    if (slot == 3) ch = 2;
    return ch;
  endfunction

  // three-position switch: below center gives 1, above gives -1
  function automatic logic signed [SwW-1:0] switch_sign(input logic [ChanW-1:0] raw);
    logic signed [SwW-1:0] s;
    if (!raw[ChanW-1]) s = SwPos;
    else if (raw == ChanCenter) s = SwZero;
    else s = SwNeg;
    return s;
  endfunction

endpackage

/* rtl/sfsd_frame_asm.sv */
// Byte framing for the SBUS decoder: tracks the byte position, shifts in the
// payload bytes and holds one finished frame. Depends on sfsd_pkg.
module sfsd_frame_asm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [sfsd_pkg::ByteW-1:0] data_byte_i,
  input  logic                       frame_start_i,
  output logic                       frm_valid_o,
  input  logic                       frm_take_i,
  output sfsd_pkg::frame_t           frm_o
);

  logic [sfsd_pkg::IdxW-1:0]        idx_q, idx_d;
  logic                             open_q, open_d;
  logic [sfsd_pkg::PayloadBits-1:0] pay_q, pay_d;
  logic                             frm_vld_q, frm_vld_d;
  sfsd_pkg::frame_t                 frm_q, frm_d;
  logic                             in_acc;
  logic                             emit;

  // frame register is free when empty or being drained this cycle
  assign in_ready_o = !frm_vld_q || frm_take_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // byte position tracking
  always_comb begin
    idx_d  = idx_q;
    open_d = open_q;
    pay_d  = pay_q;
    emit   = 1'b0;
    if (in_acc) begin
      priority if (frame_start_i) begin
        open_d = 1'b1;
        idx_d  = sfsd_pkg::IdxFirst;
      end else if (!open_q) begin
        open_d = 1'b0;
      end else if (idx_q >= sfsd_pkg::IdxFirst && idx_q <= sfsd_pkg::IdxLast) begin
        pay_d = {data_byte_i, pay_q[sfsd_pkg::PayloadBits-1:sfsd_pkg::ByteW]};
        idx_d = idx_q + sfsd_pkg::IdxW'(1);
      end else if (idx_q == sfsd_pkg::IdxFlag) begin
        emit   = 1'b1;
        open_d = 1'b0;
        idx_d  = '0;
      end else begin
        open_d = 1'b0;
        idx_d  = '0;
      end
    end
  end

  // finished frame register
  always_comb begin
    frm_vld_d = frm_vld_q;
    frm_d     = frm_q;
    if (emit) begin
      frm_vld_d       = 1'b1;
      frm_d.chans     = pay_q[sfsd_pkg::ChanBits-1:0];
      frm_d.link_lost = data_byte_i[sfsd_pkg::FrameLostBit];
      frm_d.failsafe  = data_byte_i[sfsd_pkg::FailsafeBit];
    end else if (frm_take_i) begin
      frm_vld_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      open_q    <= 1'b0;
      frm_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      open_q    <= open_d;
      frm_vld_q <= frm_vld_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
    frm_q <= frm_d;
  end

  assign frm_valid_o = frm_vld_q;
  assign frm_o       = frm_q;

endmodule

/* rtl/sfsd_stick_map.sv */
// One stick channel: centers the 11-bit raw value and scales it to +-862
// with round half up, via a constant reciprocal multiply. Depends on sfsd_pkg.
module sfsd_stick_map (
  input  logic        [sfsd_pkg::ChanW-1:0]  raw_i,
  output logic signed [sfsd_pkg::StickW-1:0] stick_o
);

  logic                          neg;
  logic [sfsd_pkg::ChanW-1:0]    mag;
  logic [sfsd_pkg::CoefW-1:0]    coef;
  logic [sfsd_pkg::CoefW-1:0]    bias;
  logic [sfsd_pkg::ProdW-1:0]    prod;
  logic [sfsd_pkg::MagW-1:0]     q;

  // below center the magnitude is 1024 - raw
  assign neg  = !raw_i[sfsd_pkg::ChanW-1];
  assign mag  = neg ? (sfsd_pkg::ChanCenter - raw_i)
                    : {1'b0, raw_i[sfsd_pkg::ChanW-2:0]};
  assign coef = neg ? sfsd_pkg::NegCoef : sfsd_pkg::PosCoef;
  assign bias = neg ? sfsd_pkg::NegBias : sfsd_pkg::PosBias;

  // scaled magnitude, exact floor for the full input range
  assign prod = sfsd_pkg::ProdW'(mag) * sfsd_pkg::ProdW'(coef) + sfsd_pkg::ProdW'(bias);
  assign q    = prod[sfsd_pkg::ScaleShift +: sfsd_pkg::MagW];

  // restore sign
  assign stick_o = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule

/* rtl/sbus_frame_stick_decoder.sv */
// SBUS frame stick decoder, top level: byte framing, stick and switch mapping
// and the result register. Depends on sfsd_pkg, sfsd_frame_asm, sfsd_stick_map.
// Flag byte -> frame register -> result register, which drives out_valid_o.
// Throughput: one byte per cycle; frame and result registers form a two-deep
// pipe, the input stalls only while both hold a word and the output is stalled.
// Reset (rst_ni low, asynchronous): no frame open, byte position 0, no result.
module sbus_frame_stick_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic        [sfsd_pkg::ByteW-1:0]   data_byte_i,
  input  logic                                frame_start_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sfsd_pkg::StickW-1:0]  stick_0_o,
  output logic signed [sfsd_pkg::StickW-1:0]  stick_1_o,
  output logic signed [sfsd_pkg::StickW-1:0]  stick_2_o,
  output logic signed [sfsd_pkg::StickW-1:0]  stick_3_o,
  output logic signed [sfsd_pkg::StickW-1:0]  stick_4_o,
  output logic signed [sfsd_pkg::StickW-1:0]  stick_5_o,
  output logic signed [sfsd_pkg::SwW-1:0]     switch_0_o,
  output logic signed [sfsd_pkg::SwW-1:0]     switch_1_o,
  output logic signed [sfsd_pkg::SwW-1:0]     switch_2_o,
  output logic signed [sfsd_pkg::SwW-1:0]     switch_3_o,
  output logic                                link_lost_o,
  output logic                                failsafe_o
);

  logic                                frm_valid;
  logic                                frm_take;
  sfsd_pkg::frame_t                    frm;
  logic                                out_free;
  logic signed [sfsd_pkg::StickW-1:0]  stick_d [sfsd_pkg::NumSticks];
  logic signed [sfsd_pkg::StickW-1:0]  stick_q [sfsd_pkg::NumSticks];
  logic signed [sfsd_pkg::SwW-1:0]     sw_d [sfsd_pkg::NumSw];
  logic signed [sfsd_pkg::SwW-1:0]     sw_q [sfsd_pkg::NumSw];
  logic                                lost_q, fs_q;
  logic                                out_vld_q, out_vld_d;

  // byte framing and frame register
  sfsd_frame_asm u_asm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .frame_start_i(frame_start_i),
    .frm_valid_o  (frm_valid),
    .frm_take_i   (frm_take),
    .frm_o        (frm)
  );

  // stick mapping, one unit per stick
  for (genvar k = 0; k < sfsd_pkg::NumSticks; k++) begin : g_stick
    sfsd_stick_map u_map (
      .raw_i  (frm.chans[sfsd_pkg::stick_chan(k)*sfsd_pkg::ChanW +: sfsd_pkg::ChanW]),
      .stick_o(stick_d[k])
    );
  end

  // switch decode
  for (genvar k = 0; k < sfsd_pkg::NumSw; k++) begin : g_sw
    assign sw_d[k] = sfsd_pkg::switch_sign(
      frm.chans[(sfsd_pkg::SwBase + k)*sfsd_pkg::ChanW +: sfsd_pkg::ChanW]);
  end

  // result register handshake
  assign out_free  = !out_vld_q || out_ready_i;
  assign frm_take  = frm_valid && out_free;

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_free) out_vld_d = frm_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (frm_take) begin
      stick_q <= stick_d;
      sw_q    <= sw_d;
      lost_q  <= frm.link_lost;
      fs_q    <= frm.failsafe;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign stick_0_o    = stick_q[0];
  assign stick_1_o    = stick_q[1];
  assign stick_2_o    = stick_q[2];
  assign stick_3_o    = stick_q[3];
  assign stick_4_o    = stick_q[4];
  assign stick_5_o    = stick_q[5];
  assign switch_0_o   = sw_q[0];
  assign switch_1_o   = sw_q[1];
  assign switch_2_o   = sw_q[2];
  assign switch_3_o   = sw_q[3];
  assign link_lost_o  = lost_q;
  assign failsafe_o   = fs_q;

endmodule

/* rtl/sfsd_checker.sv */
// Port-level checks for the SBUS frame stick decoder, bound to the top level.
// Depends on sfsd_pkg and sbus_frame_stick_decoder.
module sfsd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [sfsd_pkg::StickW-1:0]  stick_0_o,
  input logic signed [sfsd_pkg::StickW-1:0]  stick_5_o,
  input logic signed [sfsd_pkg::SwW-1:0]     switch_0_o,
  input logic signed [sfsd_pkg::SwW-1:0]     switch_3_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(stick_0_o) && $stable(switch_3_o))
    else $error("result word changed while stalled");

  // with the output side empty, the input never stalls
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // mapped sticks 0 and 5 stay in range
  a_stick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> stick_0_o <= 11'sd862 && stick_0_o >= -11'sd862 &&
                    stick_5_o <= 11'sd862 && stick_5_o >= -11'sd862)
    else $error("stick value out of range");

  // switch code is never the unused pattern
  a_switch_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> switch_0_o != -2'sd2 && switch_3_o != -2'sd2)
    else $error("switch code out of range");

endmodule

bind sbus_frame_stick_decoder sfsd_checker u_sfsd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .stick_0_o  (stick_0_o),
  .stick_5_o  (stick_5_o),
  .switch_0_o (switch_0_o),
  .switch_3_o (switch_3_o)
);
